// ===== hw/rtl/prab_pkg.sv =====
// ----------------------------------------------------------------------------
// prab_pkg: shared constants for the point rotation pipeline
// Fixed widths, the angle reduction reciprocals and the CORDIC arctangent
// table in units of a 32-bit phase, where 2^32 is one full turn.
// ----------------------------------------------------------------------------
package prab_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 16;

    localparam int ANGLE_WIDTH  = 32;
    localparam int PHASE_WIDTH  = 32;
    localparam int CORDIC_WIDTH = 32;
    localparam int FRAC_BITS    = 30;
    localparam int ATAN_ENTRIES = 32;

    // Register stages in the angle to phase converter.
    localparam int PHASE_LATENCY = 6;

    // Whole degrees: bias that makes a signed 16-bit degree count positive
    // (a multiple of 360), and a reciprocal that underestimates /360 by < 1.
    localparam int                DEG_BITS   = 17;
    localparam logic [16:0]       DEG_BIAS   = 17'd33120;
    localparam logic [12:0]       DEG_RECIP  = 13'd5825;
    localparam int                DEG_SHIFT  = 21;
    localparam logic [8:0]        DEG_TURN   = 9'd360;

    // Exact division by 45: 25-bit dividend (shift 31), 19-bit dividend (shift 25).
    localparam logic [25:0]       DIV45_RECIP_WIDE   = 26'd47721859;
    localparam int                DIV45_SHIFT_WIDE   = 31;
    localparam logic [19:0]       DIV45_RECIP_NARROW = 20'd745655;
    localparam int                DIV45_SHIFT_NARROW = 25;
    localparam logic [5:0]        DIV45              = 6'd45;
    // Rounding term of the phase scaling, already divided by eight.
    localparam logic [12:0]       PHASE_ROUND        = 13'd22;

    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic signed [PHASE_WIDTH-1:0]  PHASE_QUARTER   = 32'sd1073741824;
    localparam logic [PHASE_WIDTH-1:0]         PHASE_HALF      = 32'h8000_0000;

    localparam logic signed [PHASE_WIDTH-1:0] ATAN_PHASE [ATAN_ENTRIES] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

endpackage

// ===== hw/rtl/prab_phase.sv =====
// ----------------------------------------------------------------------------
// prab_phase: degrees to phase converter
// Reduces a signed Q16.16 angle in degrees modulo 360 and scales it to a
// 32-bit phase, rounding to nearest, over six register stages.
// ----------------------------------------------------------------------------
module prab_phase (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [prab_pkg::ANGLE_WIDTH-1:0] angle,
    output logic                            out_valid,
    output logic [prab_pkg::PHASE_WIDTH-1:0] phase
);
    import prab_pkg::*;

    logic [PHASE_LATENCY-1:0] vld_reg;

    logic [DEG_BITS-1:0] hp_reg;
    logic [15:0]         lo1_reg;
    logic [7:0]          q_reg;
    logic [DEG_BITS-1:0] hp2_reg;
    logic [15:0]         lo2_reg;
    logic [24:0]         m3_reg;
    logic [18:0]         a4_reg;
    logic [24:0]         m4_reg;
    logic [18:0]         a5_reg;
    logic [18:0]         v5_reg;
    logic [PHASE_WIDTH-1:0] phase_reg;

    logic [DEG_BITS-1:0] hp_next;
    logic [29:0]         q_prod;
    logic [7:0]          q_next;
    logic [DEG_BITS-1:0] r_raw;
    logic [DEG_BITS-1:0] r_fix;
    logic [24:0]         m3_next;
    logic [50:0]         a_prod;
    logic [18:0]         a4_next;
    logic [24:0]         b_wide;
    logic [18:0]         v5_next;
    logic [38:0]         inner_prod;
    logic [12:0]         inner;
    logic [PHASE_WIDTH-1:0] phase_next;

    always_comb begin
        // Whole degrees are reduced apart from the fraction, which passes as it is.
        hp_next    = {angle[ANGLE_WIDTH-1], angle[ANGLE_WIDTH-1:16]} + DEG_BIAS;
        q_prod     = 30'(hp_reg) * 30'(DEG_RECIP);
        q_next     = q_prod[DEG_SHIFT +: 8];
        r_raw      = hp2_reg - DEG_BITS'(q_reg) * DEG_BITS'(DEG_TURN);
        r_fix      = (r_raw >= DEG_BITS'(DEG_TURN)) ? r_raw - DEG_BITS'(DEG_TURN) : r_raw;
        m3_next    = {r_fix[8:0], lo2_reg};
        // phase = floor((m * 8192 + 22) / 45), split as m = 45a + b.
        a_prod     = 51'(m3_reg) * 51'(DIV45_RECIP_WIDE);
        a4_next    = a_prod[DIV45_SHIFT_WIDE +: 19];
        b_wide     = m4_reg - 25'(25'(a4_reg) * 25'(DIV45));
        v5_next    = {b_wide[5:0], PHASE_ROUND};
        inner_prod = 39'(v5_reg) * 39'(DIV45_RECIP_NARROW);
        inner      = inner_prod[DIV45_SHIFT_NARROW +: 13];
        phase_next = {a5_reg, inner};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[PHASE_LATENCY-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hp_reg    <= hp_next;
            lo1_reg   <= angle[15:0];
            q_reg     <= q_next;
            hp2_reg   <= hp_reg;
            lo2_reg   <= lo1_reg;
            m3_reg    <= m3_next;
            a4_reg    <= a4_next;
            m4_reg    <= m3_reg;
            a5_reg    <= a4_reg;
            v5_reg    <= v5_next;
            phase_reg <= phase_next;
        end
    end

    assign out_valid = vld_reg[PHASE_LATENCY-1];
    assign phase     = phase_reg;

endmodule

// ===== hw/rtl/prab_cordic.sv =====
// ----------------------------------------------------------------------------
// prab_cordic: pipelined CORDIC rotator
// Folds the phase into the right half plane, rotates the gain-compensated
// unit vector through one register stage per iteration and restores the
// quadrant, giving cosine and sine in Q1.30.
// ----------------------------------------------------------------------------
module prab_cordic #(
    parameter int CORDIC_STAGES = prab_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [prab_pkg::PHASE_WIDTH-1:0]        phase,
    output logic                                    out_valid,
    output logic signed [prab_pkg::CORDIC_WIDTH-1:0] cos_q30,
    output logic signed [prab_pkg::CORDIC_WIDTH-1:0] sin_q30
);
    import prab_pkg::*;

    logic signed [CORDIC_WIDTH-1:0] x_reg [CORDIC_STAGES+1];
    logic signed [CORDIC_WIDTH-1:0] y_reg [CORDIC_STAGES+1];
    logic signed [PHASE_WIDTH-1:0]  z_reg [CORDIC_STAGES];
    logic [CORDIC_STAGES:0]         flip_reg;
    logic [CORDIC_STAGES+1:0]       vld_reg;
    logic signed [CORDIC_WIDTH-1:0] cos_reg;
    logic signed [CORDIC_WIDTH-1:0] sin_reg;

    logic signed [PHASE_WIDTH-1:0] z_in;
    logic                          flip_next;
    logic signed [PHASE_WIDTH-1:0] z_next;

    always_comb begin
        z_in      = signed'(phase);
        flip_next = (z_in > PHASE_QUARTER) || (z_in < -PHASE_QUARTER);
        // Moving by half a turn toggles the top bit; the result stays in range.
        z_next    = flip_next ? signed'(phase ^ PHASE_HALF) : z_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_STAGES:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= z_next;
            flip_reg[0] <= flip_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        logic signed [CORDIC_WIDTH-1:0] xs;
        logic signed [CORDIC_WIDTH-1:0] ys;
        logic signed [CORDIC_WIDTH-1:0] x_next;
        logic signed [CORDIC_WIDTH-1:0] y_next;
        logic                           ccw;

        always_comb begin
            xs  = x_reg[i] >>> i;
            ys  = y_reg[i] >>> i;
            // A residual of zero rotates counterclockwise.
            ccw = !z_reg[i][PHASE_WIDTH-1];
            if (ccw) begin
                x_next = x_reg[i] - ys;
                y_next = y_reg[i] + xs;
            end else begin
                x_next = x_reg[i] + ys;
                y_next = y_reg[i] - xs;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                flip_reg[i+1] <= flip_reg[i];
            end
        end

        // The last iteration has no use for a residual angle.
        if (i + 1 < CORDIC_STAGES) begin : g_resid
            always_ff @(posedge aclk) begin
                if (en) begin
                    z_reg[i+1] <= ccw ? z_reg[i] - ATAN_PHASE[i] : z_reg[i] + ATAN_PHASE[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= flip_reg[CORDIC_STAGES] ? -x_reg[CORDIC_STAGES] : x_reg[CORDIC_STAGES];
            sin_reg <= flip_reg[CORDIC_STAGES] ? -y_reg[CORDIC_STAGES] : y_reg[CORDIC_STAGES];
        end
    end

    assign out_valid = vld_reg[CORDIC_STAGES+1];
    assign cos_q30   = cos_reg;
    assign sin_q30   = sin_reg;

endmodule

// ===== hw/rtl/point_rotate_about_pivot.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_pivot: rotate a 2D point about a pivot
// Subtracts the pivot, rotates the offset by an angle in degrees using a
// pipelined CORDIC and adds the pivot back, saturating each coordinate.
//
//  Channel  Handshake          Words carried                              Dir
//  s_       s_valid, s_ready   point_x, point_y, pivot_x, pivot_y, angle  in
//  m_       m_valid, m_ready   rotated_x, rotated_y, saturated            out
//
// One word is taken every cycle; a word passes CORDIC_STAGES + 12 register
// stages (28 at the default), set by the CORDIC iterations and the split
// wide multiplies. The whole pipeline advances together and holds while a
// finished word waits on m_ready, so s_ready is m_ready while m_valid is high.
// Reset (aresetn, synchronous) clears the valid bits only.
// ----------------------------------------------------------------------------
module point_rotate_about_pivot #(
    parameter int COORD_WIDTH   = prab_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = prab_pkg::CORDIC_STAGES_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [COORD_WIDTH-1:0]          s_point_x,
    input  logic signed [COORD_WIDTH-1:0]          s_point_y,
    input  logic signed [COORD_WIDTH-1:0]          s_pivot_x,
    input  logic signed [COORD_WIDTH-1:0]          s_pivot_y,
    input  logic signed [prab_pkg::ANGLE_WIDTH-1:0] s_angle_degrees,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [COORD_WIDTH-1:0]          m_rotated_x,
    output logic signed [COORD_WIDTH-1:0]          m_rotated_y,
    output logic                                   m_saturated
);
    import prab_pkg::*;

    localparam int DIFF_WIDTH = COORD_WIDTH + 1;
    localparam int LOW_WIDTH  = (DIFF_WIDTH + 1) / 2;
    localparam int HIGH_WIDTH = DIFF_WIDTH - LOW_WIDTH;
    localparam int LP_WIDTH   = LOW_WIDTH + 1 + CORDIC_WIDTH;
    localparam int HP_WIDTH   = HIGH_WIDTH + CORDIC_WIDTH;
    localparam int LS_WIDTH   = LP_WIDTH + 2;
    localparam int HS_WIDTH   = HP_WIDTH + 1;
    localparam int TOT_WIDTH  = DIFF_WIDTH + CORDIC_WIDTH + 2;
    localparam int Q_WIDTH    = TOT_WIDTH - FRAC_BITS;
    localparam int SUM_WIDTH  = Q_WIDTH + 1;
    localparam int TOP_BITS   = SUM_WIDTH - COORD_WIDTH + 1;
    localparam int SIDE_DEPTH = PHASE_LATENCY + CORDIC_STAGES + 2;
    localparam logic signed [LS_WIDTH-1:0] ROUND_HALF = LS_WIDTH'(1) <<< (FRAC_BITS - 1);

    logic en;
    logic phase_valid;
    logic [PHASE_WIDTH-1:0] phase;
    logic trig_valid;
    logic signed [CORDIC_WIDTH-1:0] cos_q30;
    logic signed [CORDIC_WIDTH-1:0] sin_q30;

    // Offsets and pivot travel alongside the angle path.
    logic signed [DIFF_WIDTH-1:0]  dx_reg [SIDE_DEPTH];
    logic signed [DIFF_WIDTH-1:0]  dy_reg [SIDE_DEPTH];
    logic signed [COORD_WIDTH-1:0] cx_reg [SIDE_DEPTH+3];
    logic signed [COORD_WIDTH-1:0] cy_reg [SIDE_DEPTH+3];
    logic [3:0]                    vld_reg;

    logic signed [DIFF_WIDTH-1:0] dx_next;
    logic signed [DIFF_WIDTH-1:0] dy_next;

    // Partial products: low part of the offset is unsigned, high part signed.
    logic signed [LP_WIDTH-1:0] xc_lo_reg, ys_lo_reg, xs_lo_reg, yc_lo_reg;
    logic signed [HP_WIDTH-1:0] xc_hi_reg, ys_hi_reg, xs_hi_reg, yc_hi_reg;
    logic signed [LP_WIDTH-1:0] xc_lo_next, ys_lo_next, xs_lo_next, yc_lo_next;
    logic signed [HP_WIDTH-1:0] xc_hi_next, ys_hi_next, xs_hi_next, yc_hi_next;
    logic signed [LOW_WIDTH:0]    dx_lo, dy_lo;
    logic signed [HIGH_WIDTH-1:0] dx_hi, dy_hi;

    logic signed [LS_WIDTH-1:0] rx_lo_reg, ry_lo_reg, rx_lo_next, ry_lo_next;
    logic signed [HS_WIDTH-1:0] rx_hi_reg, ry_hi_reg, rx_hi_next, ry_hi_next;

    logic signed [TOT_WIDTH-1:0] rx_tot, ry_tot;
    logic signed [Q_WIDTH-1:0]   rx_q_reg, ry_q_reg, rx_q_next, ry_q_next;

    logic signed [SUM_WIDTH-1:0]   rx_sum, ry_sum;
    logic [TOP_BITS-1:0]           rx_top, ry_top;
    logic                          rx_ovf, ry_ovf;
    logic signed [COORD_WIDTH-1:0] rx_next, ry_next;
    logic signed [COORD_WIDTH-1:0] rx_reg, ry_reg;
    logic                          sat_reg;

    assign en      = !vld_reg[3] || m_ready;
    assign s_ready = en;

    prab_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .angle     (s_angle_degrees),
        .out_valid (phase_valid),
        .phase     (phase)
    );

    prab_cordic #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (phase_valid),
        .phase     (phase),
        .out_valid (trig_valid),
        .cos_q30   (cos_q30),
        .sin_q30   (sin_q30)
    );

    assign dx_next = DIFF_WIDTH'(s_point_x) - DIFF_WIDTH'(s_pivot_x);
    assign dy_next = DIFF_WIDTH'(s_point_y) - DIFF_WIDTH'(s_pivot_y);

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg[0] <= dx_next;
            dy_reg[0] <= dy_next;
            cx_reg[0] <= s_pivot_x;
            cy_reg[0] <= s_pivot_y;
            for (int k = 1; k < SIDE_DEPTH; k++) begin
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
            end
            for (int k = 1; k < SIDE_DEPTH + 3; k++) begin
                cx_reg[k] <= cx_reg[k-1];
                cy_reg[k] <= cy_reg[k-1];
            end
        end
    end

    // First product stage: eight narrow multiplies in parallel.
    always_comb begin
        dx_lo      = signed'({1'b0, dx_reg[SIDE_DEPTH-1][LOW_WIDTH-1:0]});
        dy_lo      = signed'({1'b0, dy_reg[SIDE_DEPTH-1][LOW_WIDTH-1:0]});
        dx_hi      = signed'(dx_reg[SIDE_DEPTH-1][DIFF_WIDTH-1:LOW_WIDTH]);
        dy_hi      = signed'(dy_reg[SIDE_DEPTH-1][DIFF_WIDTH-1:LOW_WIDTH]);
        xc_lo_next = LP_WIDTH'(dx_lo) * LP_WIDTH'(cos_q30);
        ys_lo_next = LP_WIDTH'(dy_lo) * LP_WIDTH'(sin_q30);
        xs_lo_next = LP_WIDTH'(dx_lo) * LP_WIDTH'(sin_q30);
        yc_lo_next = LP_WIDTH'(dy_lo) * LP_WIDTH'(cos_q30);
        xc_hi_next = HP_WIDTH'(dx_hi) * HP_WIDTH'(cos_q30);
        ys_hi_next = HP_WIDTH'(dy_hi) * HP_WIDTH'(sin_q30);
        xs_hi_next = HP_WIDTH'(dx_hi) * HP_WIDTH'(sin_q30);
        yc_hi_next = HP_WIDTH'(dy_hi) * HP_WIDTH'(cos_q30);
    end

    always_comb begin
        rx_lo_next = LS_WIDTH'(xc_lo_reg) - LS_WIDTH'(ys_lo_reg) + ROUND_HALF;
        ry_lo_next = LS_WIDTH'(xs_lo_reg) + LS_WIDTH'(yc_lo_reg) + ROUND_HALF;
        rx_hi_next = HS_WIDTH'(xc_hi_reg) - HS_WIDTH'(ys_hi_reg);
        ry_hi_next = HS_WIDTH'(xs_hi_reg) + HS_WIDTH'(yc_hi_reg);
    end

    always_comb begin
        rx_tot    = (TOT_WIDTH'(rx_hi_reg) <<< LOW_WIDTH) + TOT_WIDTH'(rx_lo_reg);
        ry_tot    = (TOT_WIDTH'(ry_hi_reg) <<< LOW_WIDTH) + TOT_WIDTH'(ry_lo_reg);
        rx_q_next = signed'(rx_tot[TOT_WIDTH-1:FRAC_BITS]);
        ry_q_next = signed'(ry_tot[TOT_WIDTH-1:FRAC_BITS]);
    end

    // Saturate when the coordinate's sign bit and the bits above it disagree.
    always_comb begin
        rx_sum  = SUM_WIDTH'(rx_q_reg) + SUM_WIDTH'(cx_reg[SIDE_DEPTH+2]);
        ry_sum  = SUM_WIDTH'(ry_q_reg) + SUM_WIDTH'(cy_reg[SIDE_DEPTH+2]);
        rx_top  = rx_sum[SUM_WIDTH-1:COORD_WIDTH-1];
        ry_top  = ry_sum[SUM_WIDTH-1:COORD_WIDTH-1];
        rx_ovf  = !((&rx_top) || !(|rx_top));
        ry_ovf  = !((&ry_top) || !(|ry_top));
        rx_next = rx_ovf ? signed'({rx_sum[SUM_WIDTH-1], {(COORD_WIDTH-1){~rx_sum[SUM_WIDTH-1]}}})
                         : signed'(rx_sum[COORD_WIDTH-1:0]);
        ry_next = ry_ovf ? signed'({ry_sum[SUM_WIDTH-1], {(COORD_WIDTH-1){~ry_sum[SUM_WIDTH-1]}}})
                         : signed'(ry_sum[COORD_WIDTH-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[2:0], trig_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            xc_lo_reg <= xc_lo_next;
            ys_lo_reg <= ys_lo_next;
            xs_lo_reg <= xs_lo_next;
            yc_lo_reg <= yc_lo_next;
            xc_hi_reg <= xc_hi_next;
            ys_hi_reg <= ys_hi_next;
            xs_hi_reg <= xs_hi_next;
            yc_hi_reg <= yc_hi_next;
            rx_lo_reg <= rx_lo_next;
            ry_lo_reg <= ry_lo_next;
            rx_hi_reg <= rx_hi_next;
            ry_hi_reg <= ry_hi_next;
            rx_q_reg  <= rx_q_next;
            ry_q_reg  <= ry_q_next;
            rx_reg    <= rx_next;
            ry_reg    <= ry_next;
            sat_reg   <= rx_ovf | ry_ovf;
        end
    end

    assign m_valid     = vld_reg[3];
    assign m_rotated_x = rx_reg;
    assign m_rotated_y = ry_reg;
    assign m_saturated = sat_reg;

endmodule

// ===== hw/rtl/prab_checker.sv =====
// ----------------------------------------------------------------------------
// prab_checker: port-level checks for point_rotate_about_pivot
// Watches the two channels and the saturation flag over time.
// ----------------------------------------------------------------------------
module prab_checker #(
    parameter int COORD_WIDTH = prab_pkg::COORD_WIDTH_DEF
) (
    input logic                                   aclk,
    input logic                                   aresetn,
    input logic                                   s_valid,
    input logic                                   s_ready,
    input logic signed [COORD_WIDTH-1:0]          s_point_x,
    input logic signed [COORD_WIDTH-1:0]          s_point_y,
    input logic signed [COORD_WIDTH-1:0]          s_pivot_x,
    input logic signed [COORD_WIDTH-1:0]          s_pivot_y,
    input logic signed [prab_pkg::ANGLE_WIDTH-1:0] s_angle_degrees,
    input logic                                   m_valid,
    input logic                                   m_ready,
    input logic signed [COORD_WIDTH-1:0]          m_rotated_x,
    input logic signed [COORD_WIDTH-1:0]          m_rotated_y,
    input logic                                   m_saturated
);
    localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // A waiting input word stays offered and unchanged until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_point_x) && $stable(s_point_y)
            && $stable(s_pivot_x) && $stable(s_pivot_y) && $stable(s_angle_degrees))
        else $error("input word changed while waiting");

    // A stalled result word keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rotated_x)
            && $stable(m_rotated_y) && $stable(m_saturated))
        else $error("result word changed while stalled");

    // The input side only waits when a finished word is held at the output.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input stalled without output back-pressure");

    // A clipped result shows a coordinate at a range limit.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> m_rotated_x == COORD_MAX || m_rotated_x == COORD_MIN
            || m_rotated_y == COORD_MAX || m_rotated_y == COORD_MIN)
        else $error("saturation flagged with no coordinate at a limit");

    // An accepted word in flight never makes the input ready drop while the
    // output is empty and idle on the next cycle.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> s_ready || m_valid)
        else $error("pipeline stalled with nothing to deliver");

endmodule

bind point_rotate_about_pivot prab_checker #(.COORD_WIDTH(COORD_WIDTH)) u_prab_checker (.*);

// ===== verif/point_rotate_about_pivot_tb.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_pivot_tb: self-checking bench for the pivot rotator
// Drives a directed set of points and angles, then random batches, with
// random idling on both channels. Each word taken by the block is predicted
// with an exact CORDIC and rounding model and compared field by field with
// the words that come back, in order.
// ----------------------------------------------------------------------------
module point_rotate_about_pivot_tb;

    localparam int CW         = prab_pkg::COORD_WIDTH_DEF;
    localparam int AW         = prab_pkg::ANGLE_WIDTH;
    localparam int STAGES     = prab_pkg::CORDIC_STAGES_DEF;
    localparam int PIPE_DEPTH = STAGES + 12;

    localparam int RANDOM_BATCH   = 510;
    localparam int RANDOM_BATCHES = 3;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam longint FULL_TURN_Q16 = 64'sd23592960;
    localparam longint TURN_PHASE    = 64'sd4294967296;
    localparam longint HALF_PHASE    = 64'sd2147483648;
    localparam longint QUARTER_PHASE = 64'sd1073741824;
    localparam longint GAIN_Q30      = 64'sd652032874;

    localparam logic signed [127:0] ROUND_Q30 = 128'sd536870912;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic signed [CW-1:0] pivot_x;
        logic signed [CW-1:0] pivot_y;
        logic signed [AW-1:0] angle;
    } rotation_word_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic                 sat;
    } rotated_point_t;

    // Arctangent of 2^-i in units of a 32-bit phase.
    int arctan_phase [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1, 1, 0
    };

    logic                 aclk            = 1'b0;
    logic                 aresetn         = 1'b0;
    logic                 s_valid         = 1'b0;
    logic                 s_ready;
    logic signed [CW-1:0] s_point_x       = '0;
    logic signed [CW-1:0] s_point_y       = '0;
    logic signed [CW-1:0] s_pivot_x       = '0;
    logic signed [CW-1:0] s_pivot_y       = '0;
    logic signed [AW-1:0] s_angle_degrees = '0;
    logic                 m_valid;
    logic                 m_ready         = 1'b0;
    logic signed [CW-1:0] m_rotated_x;
    logic signed [CW-1:0] m_rotated_y;
    logic                 m_saturated;

    rotation_word_t pending_words [$];
    rotated_point_t expected_points [$];

    int mismatches     = 0;
    int words_accepted = 0;
    int results_seen   = 0;
    int send_gap       = 0;
    int ready_wait     = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    bit sender_calm    = 1'b0;
    bit receiver_calm  = 1'b0;

    point_rotate_about_pivot dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_point_x       (s_point_x),
        .s_point_y       (s_point_y),
        .s_pivot_x       (s_pivot_x),
        .s_pivot_y       (s_pivot_y),
        .s_angle_degrees (s_angle_degrees),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rotated_x     (m_rotated_x),
        .m_rotated_y     (m_rotated_y),
        .m_saturated     (m_saturated)
    );

    initial begin : clock_gen
        forever #6 aclk = ~aclk;
    end

    function automatic rotated_point_t rotate_about_pivot(input rotation_word_t w);
        longint              reduced;
        longint              phase;
        longint              resid;
        longint              cx;
        longint              sy;
        longint              xs;
        longint              ys;
        logic signed [127:0] off_x;
        logic signed [127:0] off_y;
        logic signed [127:0] cos_w;
        logic signed [127:0] sin_w;
        logic signed [127:0] base_x;
        logic signed [127:0] base_y;
        logic signed [127:0] full_x;
        logic signed [127:0] full_y;
        logic signed [127:0] top;
        logic signed [127:0] bottom;
        bit                  flip;
        rotated_point_t      r;

        off_x  = $signed(w.point_x) - $signed(w.pivot_x);
        off_y  = $signed(w.point_y) - $signed(w.pivot_y);
        base_x = $signed(w.pivot_x);
        base_y = $signed(w.pivot_y);

        reduced = longint'($signed(w.angle)) % FULL_TURN_Q16;
        if (reduced < 0) begin
            reduced += FULL_TURN_Q16;
        end
        phase = ((reduced * 65536 + 180) / 360) % TURN_PHASE;

        // Fold the phase into the right half plane; the CORDIC only converges
        // within a quarter turn either side of zero.
        resid = (phase >= HALF_PHASE) ? phase - TURN_PHASE : phase;
        flip  = 1'b0;
        if (resid > QUARTER_PHASE) begin
            resid -= HALF_PHASE;
            flip = 1'b1;
        end else if (resid < -QUARTER_PHASE) begin
            resid += HALF_PHASE;
            flip = 1'b1;
        end

        cx = GAIN_Q30;
        sy = 0;
        for (int i = 0; i < STAGES && i < 32; i++) begin
            xs = cx >>> i;
            ys = sy >>> i;
            if (resid >= 0) begin
                cx -= ys;
                sy += xs;
                resid -= arctan_phase[i];
            end else begin
                cx += ys;
                sy -= xs;
                resid += arctan_phase[i];
            end
        end
        cos_w = flip ? -cx : cx;
        sin_w = flip ? -sy : sy;

        full_x = ((off_x * cos_w - off_y * sin_w + ROUND_Q30) >>> 30) + base_x;
        full_y = ((off_x * sin_w + off_y * cos_w + ROUND_Q30) >>> 30) + base_y;

        top    = (128'sd1 <<< (CW - 1)) - 1;
        bottom = -top - 1;
        r.sat  = 1'b0;
        if (full_x > top) begin
            r.x   = top[CW-1:0];
            r.sat = 1'b1;
        end else if (full_x < bottom) begin
            r.x   = bottom[CW-1:0];
            r.sat = 1'b1;
        end else begin
            r.x = full_x[CW-1:0];
        end
        if (full_y > top) begin
            r.y   = top[CW-1:0];
            r.sat = 1'b1;
        end else if (full_y < bottom) begin
            r.y   = bottom[CW-1:0];
            r.sat = 1'b1;
        end else begin
            r.y = full_y[CW-1:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] to_q16(input int value);
        return value << 16;
    endfunction

    function automatic logic [CW-1:0] random_coord();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: return r;
            1: return {{12{r[19]}}, r[19:0]};
            2: return {{4{r[27]}}, r[27:0]};
            default: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
        endcase
    endfunction

    function automatic logic [AW-1:0] random_angle();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 3))
            0: return r;
            1: return to_q16(90 * $urandom_range(0, 16) - 720);
            // Close either side of a whole number of turns.
            2: return to_q16(360 * $urandom_range(0, 180) - 32400)
                      + $urandom_range(0, 64) - 32;
            default: return {{12{r[19]}}, r[19:0]};
        endcase
    endfunction

    function automatic rotation_word_t random_word();
        rotation_word_t w;
        logic [31:0]    r;
        r         = $urandom;
        w.point_x = random_coord();
        w.point_y = random_coord();
        case ($urandom_range(0, 3))
            0, 1: begin
                w.pivot_x = random_coord();
                w.pivot_y = random_coord();
            end
            2: begin
                w.pivot_x = w.point_x;
                w.pivot_y = w.point_y;
            end
            default: begin
                w.pivot_x = w.point_x + {{20{r[11]}}, r[11:0]};
                w.pivot_y = w.point_y + {{20{r[23]}}, r[23:12]};
            end
        endcase
        w.angle = random_angle();
        return w;
    endfunction

    task automatic add_word(input logic [CW-1:0] px, input logic [CW-1:0] py,
                            input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                            input logic [AW-1:0] ang);
        rotation_word_t w;
        w.point_x = px;
        w.point_y = py;
        w.pivot_x = cx;
        w.pivot_y = cy;
        w.angle   = ang;
        pending_words.push_back(w);
    endtask

    // Sampled on the falling edge so that the clocked processes have settled.
    task automatic wait_drained();
        do begin
            @(negedge aclk);
        end while (pending_words.size() != 0 || s_valid || expected_points.size() != 0);
    endtask

    task automatic note_mismatch(input string field, input longint want_v,
                                 input longint got_v);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s mismatch on result %0d: expected %0d, got %0d",
                     field, results_seen, want_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : drive_words
        rotation_word_t w;
        int             gap;
        bit             launch;

        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            gap    = send_gap;
            launch = !s_valid;
            if (s_valid && s_ready) begin
                w.point_x = s_point_x;
                w.point_y = s_point_y;
                w.pivot_x = s_pivot_x;
                w.pivot_y = s_pivot_y;
                w.angle   = s_angle_degrees;
                expected_points.push_back(rotate_about_pivot(w));
                words_accepted++;
                if (words_accepted % 200 == 0) begin
                    sender_calm = !sender_calm;
                end
                gap    = sender_calm ? 0 : $urandom_range(0, 6);
                launch = 1'b1;
            end
            if (launch) begin
                if (gap > 0) begin
                    gap--;
                    s_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    w = pending_words.pop_front();
                    s_point_x       <= w.point_x;
                    s_point_y       <= w.point_y;
                    s_pivot_x       <= w.pivot_x;
                    s_pivot_y       <= w.pivot_y;
                    s_angle_degrees <= w.angle;
                    s_valid         <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            send_gap = gap;
        end
    end

    always @(posedge aclk) begin : check_points
        rotated_point_t want;
        int             wait_n;

        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_wait = 0;
        end else begin
            wait_n = ready_wait;
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_points.size() == 0) begin
                    note_mismatch("unexpected word, rotated_x", 0, $signed(m_rotated_x));
                end else begin
                    want = expected_points.pop_front();
                    if (m_rotated_x !== want.x) begin
                        note_mismatch("rotated_x", $signed(want.x), $signed(m_rotated_x));
                    end
                    if (m_rotated_y !== want.y) begin
                        note_mismatch("rotated_y", $signed(want.y), $signed(m_rotated_y));
                    end
                    if (m_saturated !== want.sat) begin
                        note_mismatch("saturated", want.sat, m_saturated);
                    end
                end
                if (results_seen % 150 == 0) begin
                    receiver_calm = !receiver_calm;
                end
                wait_n = receiver_calm ? 0 : $urandom_range(0, 6);
                // One long back-pressure stretch, so that the pipeline fills
                // and the input side has to stall.
                if (results_seen == 400) begin
                    hold_left = LONG_HOLD;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (wait_n > 0) begin
                wait_n--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
            ready_wait = wait_n;
        end
    end

    always @(posedge aclk) begin : watchdog
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[point_rotate_about_pivot] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Quarter turns, common angles, angle extremes and wrap-around.
        add_word(0, 0, 0, 0, 0);
        add_word(to_q16(10), 0, 0, 0, to_q16(90));
        add_word(to_q16(10), 0, 0, 0, to_q16(180));
        add_word(to_q16(10), 0, 0, 0, to_q16(270));
        add_word(to_q16(10), 0, 0, 0, to_q16(-90));
        add_word(to_q16(3), to_q16(4), to_q16(1), to_q16(1), to_q16(360));
        add_word(to_q16(10), to_q16(5), to_q16(-2), to_q16(3), to_q16(45));
        add_word(to_q16(10), to_q16(5), to_q16(-2), to_q16(3), to_q16(30));
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), 32'h7FFF_FFFF);
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), 32'h8000_0000);
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), 32'hFFFF_FFFF);
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), 32'h0000_0001);
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), 32'd23592959);
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), to_q16(-32760));
        add_word(to_q16(7), to_q16(-3), to_q16(2), to_q16(2), to_q16(90) + 1);
        // Offsets spanning the whole coordinate range, most of them clipping.
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
        add_word(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, to_q16(180));
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, to_q16(45));
        add_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, to_q16(90));
        add_word(0, 32'h7FFF_FFFF, 0, 0, to_q16(-45));
        add_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 to_q16(123) + 32'h8000);
        add_word(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                 32'h5555_5555);
        wait_drained();

        // The sender runs dry between batches until every word is back.
        for (int b = 0; b < RANDOM_BATCHES; b++) begin
            for (int n = 0; n < RANDOM_BATCH; n++) begin
                pending_words.push_back(random_word());
            end
            wait_drained();
        end

        repeat (PIPE_DEPTH + 8) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[point_rotate_about_pivot] OK");
        end else begin
            $display("[point_rotate_about_pivot] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/prab_pkg.sv
hw/rtl/prab_phase.sv
hw/rtl/prab_cordic.sv
hw/rtl/point_rotate_about_pivot.sv
hw/rtl/prab_checker.sv
verif/point_rotate_about_pivot_tb.sv
